[src/humidity_temp_frame_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the humidity and temperature frame decoder.
// Each macro builds one clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/hfd_pkg.sv]
// ----------------------------------------------------------------------------
// hfd_pkg
// Types, constants and the CRC-8 step shared by the frame decoder modules.
// ----------------------------------------------------------------------------
package hfd_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [2:0]  CHECK_INDEX = 3'd6;
    localparam int          READ_W      = 20;
    localparam int          HUM_PROD_W  = 30;
    localparam int          TMP_PROD_W  = 31;
    localparam logic [HUM_PROD_W-1:0] HUMI_SCALE = HUM_PROD_W'(1000);
    localparam logic [TMP_PROD_W-1:0] TEMP_SCALE = TMP_PROD_W'(2000);
    localparam logic signed [11:0]    TEMP_OFFSET = 12'sd500;

    // One completed frame as handed from the front to the back.
    typedef struct packed {
        logic              crc_ok;
        logic [7:0]        status;
        logic [READ_W-1:0] raw_hum;
        logic [READ_W-1:0] raw_tmp;
    } hfd_frame_t;

    // CRC-8, polynomial 0x31, MSB first, one byte per call.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[src/hfd_front.sv]
// ----------------------------------------------------------------------------
// hfd_front
// Byte counter, running CRC and frame hold; pushes one record per frame.
// ----------------------------------------------------------------------------
module hfd_front
    import hfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output logic       push,
    output hfd_frame_t push_frame
);

    logic [2:0]  count_reg, count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [47:0] hold_reg, hold_next;
    logic [2:0]  eff_count;
    logic [7:0]  crc_base;

    // A frame start restarts the frame at byte 0 whatever the count says.
    assign eff_count = frame_start ? 3'd0 : count_reg;
    assign crc_base  = (eff_count == 3'd0) ? CRC_INIT : crc_reg;

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        hold_next  = hold_reg;
        push       = 1'b0;
        if (in_fire) begin
            if (eff_count < CHECK_INDEX) begin
                crc_next   = crc8_update(crc_base, data_byte);
                hold_next  = {hold_reg[39:0], data_byte};
                count_next = eff_count + 3'd1;
            end else begin
                push       = 1'b1;
                crc_next   = CRC_INIT;
                count_next = 3'd0;
            end
        end
    end

    assign push_frame.crc_ok  = (crc_reg == data_byte);
    assign push_frame.status  = hold_reg[47:40];
    assign push_frame.raw_hum = hold_reg[39:20];
    assign push_frame.raw_tmp = hold_reg[19:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
            crc_reg   <= CRC_INIT;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

endmodule

[src/hfd_fifo.sv]
// ----------------------------------------------------------------------------
// hfd_fifo
// Small register queue of frame records between the front and the back.
// ----------------------------------------------------------------------------
module hfd_fifo
    import hfd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  hfd_frame_t wdata,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output hfd_frame_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hfd_frame_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rdata     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[src/hfd_back.sv]
// ----------------------------------------------------------------------------
// hfd_back
// Scales the readings, keeps the last good values and drives the results.
// ----------------------------------------------------------------------------
module hfd_back
    import hfd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frame_valid,
    input  hfd_frame_t         frame,
    output logic               frame_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_crc_ok,
    output logic [9:0]         m_humidity_tenths,
    output logic signed [11:0] m_temperature_tenths,
    output logic [7:0]         m_status_byte
);

    // Multiply stage.
    logic                  a_valid_reg;
    logic                  a_ok_reg;
    logic [7:0]            a_status_reg;
    logic [HUM_PROD_W-1:0] a_hprod_reg;
    logic [TMP_PROD_W-1:0] a_tprod_reg;

    // Result stage and last good values.
    logic                  m_valid_reg;
    logic                  m_ok_reg;
    logic [7:0]            m_status_reg;
    logic [9:0]            good_hum_reg, good_hum_next;
    logic signed [11:0]    good_tmp_reg, good_tmp_next;

    logic                  b_ready, a_ready, a_load, b_load;
    logic [9:0]            hum_new;
    logic signed [11:0]    tmp_new;

    assign b_ready   = !m_valid_reg || m_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign a_load    = frame_valid && a_ready;
    assign b_load    = a_valid_reg && b_ready;
    assign frame_pop = a_load;

    assign hum_new = a_hprod_reg[HUM_PROD_W-1:READ_W];
    assign tmp_new = $signed({1'b0, a_tprod_reg[TMP_PROD_W-1:READ_W]}) - TEMP_OFFSET;

    always_comb begin
        good_hum_next = good_hum_reg;
        good_tmp_next = good_tmp_reg;
        if (b_load && a_ok_reg) begin
            good_hum_next = hum_new;
            good_tmp_next = tmp_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            good_hum_reg <= '0;
            good_tmp_reg <= '0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= frame_valid;
            end
            if (b_ready) begin
                m_valid_reg <= a_valid_reg;
            end
            good_hum_reg <= good_hum_next;
            good_tmp_reg <= good_tmp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_ok_reg     <= frame.crc_ok;
            a_status_reg <= frame.status;
            a_hprod_reg  <= HUM_PROD_W'(frame.raw_hum) * HUMI_SCALE;
            a_tprod_reg  <= TMP_PROD_W'(frame.raw_tmp) * TEMP_SCALE;
        end
        if (b_load) begin
            m_ok_reg     <= a_ok_reg;
            m_status_reg <= a_status_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_crc_ok             = m_ok_reg;
    assign m_status_byte        = m_status_reg;
    assign m_humidity_tenths    = good_hum_reg;
    assign m_temperature_tenths = good_tmp_reg;

endmodule

[src/humidity_temp_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes seven-byte humidity and temperature sensor frames into readings.
// ----------------------------------------------------------------------------
// The block takes one frame byte per beat on the s_ channel and accepts a new
// byte in every cycle in which s_ready is high. Byte 0 is the status byte,
// bytes 1 to 5 carry the packed 20-bit humidity and temperature readings, and
// byte 6 is the CRC-8 check byte (polynomial 0x31, initial value 0xFF). The
// seventh byte produces one result beat on the m_ channel; the frame passes
// through the queue, the multiply stage and the result stage before m_valid
// rises. The beat carries crc_ok, the last good humidity in 0.1 % units, the
// last good temperature in 0.1 degC units and the raw status byte. A frame
// whose check byte does not match leaves the stored readings as they were.
// Raising s_frame_start on a byte makes it byte 0 of a new frame and drops
// any partial frame. The front end runs the byte count and the CRC (one
// unrolled byte step per cycle in which a byte is taken) and hands each
// completed frame to a queue of FIFO_DEPTH entries; the back end scales the
// readings in a multiply stage and a result stage. s_ready drops only while
// that queue is full, which happens when m_ready is held low long enough for
// FIFO_DEPTH frames plus the two back-end stages to pile up.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_core
    import hfd_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_crc_ok,
    output logic [9:0]         m_humidity_tenths,
    output logic signed [11:0] m_temperature_tenths,
    output logic [7:0]         m_status_byte
);

    hfd_frame_t push_frame, pop_frame;
    logic       in_fire, push, pop, q_full, q_valid;

    // A beat is taken whenever the queue has room, so the front never waits
    // on the result side as long as a slot is free.
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    hfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_data_byte),
        .frame_start (s_frame_start),
        .push        (push),
        .push_frame  (push_frame)
    );

    // The queue decouples frame completion from result delivery.
    hfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wdata     (push_frame),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .rdata     (pop_frame)
    );

    // The back end scales the readings and owns the last good values.
    hfd_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .frame_valid          (q_valid),
        .frame                (pop_frame),
        .frame_pop            (pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_crc_ok             (m_crc_ok),
        .m_humidity_tenths    (m_humidity_tenths),
        .m_temperature_tenths (m_temperature_tenths),
        .m_status_byte        (m_status_byte)
    );

endmodule

[src/hfd_checker.sv]
// ----------------------------------------------------------------------------
// hfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_decoder_core_macros.svh"

module hfd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_crc_ok,
    input logic [9:0]         m_humidity_tenths,
    input logic signed [11:0] m_temperature_tenths,
    input logic [7:0]         m_status_byte
);

    logic [9:0]         last_hum_reg;
    logic signed [11:0] last_tmp_reg;
    logic [2:0]         beats_reg;

    // Values of the last delivered result, and input beats seen up to seven.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_hum_reg <= '0;
            last_tmp_reg <= '0;
            beats_reg    <= '0;
        end else begin
            if (m_valid && m_ready) begin
                last_hum_reg <= m_humidity_tenths;
                last_tmp_reg <= m_temperature_tenths;
            end
            if (s_valid && s_ready && beats_reg != 3'd7) begin
                beats_reg <= beats_reg + 3'd1;
            end
        end
    end

    `HFD_ASSERT_NEXT(a_result_hold, m_valid && !m_ready,
        m_valid && $stable(m_crc_ok) && $stable(m_humidity_tenths) &&
        $stable(m_temperature_tenths) && $stable(m_status_byte),
        "result changed while stalled")
    `HFD_ASSERT_NOW(a_bad_crc_keeps, m_valid && !m_crc_ok,
        m_humidity_tenths == last_hum_reg && m_temperature_tenths == last_tmp_reg,
        "failed frame changed readings")
    `HFD_ASSERT_NOW(a_range, m_valid,
        m_humidity_tenths <= 10'd999 && m_temperature_tenths >= -12'sd500 &&
        m_temperature_tenths <= 12'sd1499,
        "reading out of range")
    `HFD_ASSERT_NOW(a_seven_beats, m_valid, beats_reg == 3'd7,
        "result before a full frame")

endmodule

bind humidity_temp_frame_decoder_core hfd_checker u_hfd_checker (.*);
